// ----- design/sppp_pkg.sv -----
package sppp_pkg;

   // Capture capacity in bytes and the widths that follow from it.
   localparam int CAPTURE_BYTES = 128;
   localparam int CNT_W = $clog2(CAPTURE_BYTES + 1);
   localparam int POS_W = $clog2(CAPTURE_BYTES);

   // Sync pattern, start byte and the two command packet types.
   localparam logic [47:0] SYNC_WORD = 48'hFF3FCFF3FCFF;
   localparam logic [7:0] START_BYTE = 8'hC3;
   localparam logic [7:0] CMD_TYPE_A = 8'h80;
   localparam logic [7:0] CMD_TYPE_B = 8'h85;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // Header byte positions counted after the start byte.
   localparam logic [3:0] HDR_DEST = 4'd1;
   localparam logic [3:0] HDR_SOURCE = 4'd2;
   localparam logic [3:0] HDR_TYPE = 4'd3;
   localparam logic [3:0] HDR_COMMAND = 4'd8;

   // Status codes of one capture.
   localparam logic [2:0] ST_ALL_ZERO = 3'd0;
   localparam logic [2:0] ST_ALL_ONES = 3'd1;
   localparam logic [2:0] ST_NO_SYNC = 3'd2;
   localparam logic [2:0] ST_NO_START = 3'd3;
   localparam logic [2:0] ST_SHORT_HDR = 3'd4;
   localparam logic [2:0] ST_DATA_PKT = 3'd5;
   localparam logic [2:0] ST_CMD_PKT = 3'd6;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_WANT_START,
      PH_HEADER,
      PH_DONE,
      PH_NO_START
   } phase_type;

   // One input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic last_byte;
   } beat_type;

   // One result beat.
   typedef struct packed {
      logic [2:0] status;
      logic [6:0] pattern_offset;
      logic [7:0] dest_addr;
      logic [7:0] source_addr;
      logic [7:0] packet_type;
      logic [7:0] command_code;
      logic [7:0] byte_count;
   } result_type;

endpackage

// ----- design/sppp_in_reg.sv -----
module sppp_in_reg
   import sppp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input beat_type req_beat,
   output logic req_stall,
   input logic hold,
   output logic beat_valid,
   output beat_type beat
);

   logic valid_ff;
   logic valid_in;
   beat_type beat_ff;
   logic accept;
   logic advance;

   // The held beat moves on unless the parser has to wait for the result register.
   assign advance = valid_ff && !hold;
   assign req_stall = valid_ff && hold;
   assign accept = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = advance;
   assign beat = beat_ff;

endmodule

// ----- design/sppp_parse.sv -----
module sppp_parse
   import sppp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic beat_valid,
   input beat_type beat,
   output logic res_valid,
   output result_type res
);

   logic [39:0] window_ff, window_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   phase_type phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0] hidx_ff, hidx_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] src_ff, src_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] cmd_ff, cmd_in;
   logic zeros_ff, zeros_in;
   logic ones_ff, ones_in;

   // Values after this beat is taken, before the end-of-capture reset.
   logic [39:0] win_n;
   logic [CNT_W-1:0] seen_n;
   phase_type phase_n;
   logic [POS_W-1:0] pos_n;
   logic [3:0] hidx_n;
   logic [7:0] dest_n, src_n, type_n, cmd_n;
   logic zeros_n, ones_n;
   logic take;
   logic [7:0] b;
   logic [CNT_W+7:0] cnt_ext;
   logic [POS_W+6:0] pos_ext;

   assign b = beat.data_byte;
   assign take = seen_ff < CNT_W'(CAPTURE_BYTES);

   // Sync search, start check and header capture for one byte.
   always_comb begin
      win_n = window_ff;
      seen_n = seen_ff;
      phase_n = phase_ff;
      pos_n = pos_ff;
      hidx_n = hidx_ff;
      dest_n = dest_ff;
      src_n = src_ff;
      type_n = type_ff;
      cmd_n = cmd_ff;
      zeros_n = zeros_ff;
      ones_n = ones_ff;
      if (take) begin
         if (b != BYTE_ZERO) begin
            zeros_n = 1'b0;
         end
         if (b != BYTE_ONES) begin
            ones_n = 1'b0;
         end
         unique case (phase_ff)
            PH_SEARCH: begin
               if (seen_ff >= CNT_W'(5) && {window_ff, b} == SYNC_WORD) begin
                  pos_n = POS_W'(seen_ff - CNT_W'(5));
                  phase_n = PH_WANT_START;
               end
            end
            PH_WANT_START: begin
               if (b == START_BYTE) begin
                  phase_n = PH_HEADER;
                  hidx_n = 4'd0;
               end else begin
                  phase_n = PH_NO_START;
               end
            end
            PH_HEADER: begin
               hidx_n = hidx_ff + 4'd1;
               priority if (hidx_n == HDR_DEST) begin
                  dest_n = b;
               end else if (hidx_n == HDR_SOURCE) begin
                  src_n = b;
               end else if (hidx_n == HDR_TYPE) begin
                  type_n = b;
               end else if (hidx_n == HDR_COMMAND) begin
                  cmd_n = b;
                  phase_n = PH_DONE;
               end else begin
                  // Header bytes four to seven are skipped.
               end
            end
            PH_DONE, PH_NO_START: begin
            end
            default: begin
            end
         endcase
         win_n = {window_ff[31:0], b};
         seen_n = seen_ff + CNT_W'(1);
      end
   end

   // Result of the capture, built from the updated state.
   always_comb begin
      res = '0;
      unique case (phase_n)
         PH_SEARCH: begin
            res.status = zeros_n ? ST_ALL_ZERO : (ones_n ? ST_ALL_ONES : ST_NO_SYNC);
         end
         PH_WANT_START, PH_NO_START: begin
            res.status = ST_NO_START;
         end
         PH_HEADER: begin
            res.status = ST_SHORT_HDR;
         end
         PH_DONE: begin
            res.status = (type_n == CMD_TYPE_A || type_n == CMD_TYPE_B) ?
                         ST_CMD_PKT : ST_DATA_PKT;
         end
         default: begin
            res.status = ST_NO_SYNC;
         end
      endcase
      pos_ext = (POS_W + 7)'(pos_n);
      if (res.status >= ST_NO_START) begin
         res.pattern_offset = pos_ext[6:0];
      end
      if (res.status >= ST_DATA_PKT) begin
         res.dest_addr = dest_n;
         res.source_addr = src_n;
         res.packet_type = type_n;
         res.command_code = cmd_n;
      end
      cnt_ext = (CNT_W + 8)'(seen_n);
      res.byte_count = (cnt_ext > (CNT_W + 8)'(255)) ? 8'hFF : cnt_ext[7:0];
   end

   assign res_valid = beat_valid && beat.last_byte;

   // State update; the end of a capture returns everything to reset values.
   always_comb begin
      window_in = window_ff;
      seen_in = seen_ff;
      phase_in = phase_ff;
      pos_in = pos_ff;
      hidx_in = hidx_ff;
      dest_in = dest_ff;
      src_in = src_ff;
      type_in = type_ff;
      cmd_in = cmd_ff;
      zeros_in = zeros_ff;
      ones_in = ones_ff;
      if (beat_valid) begin
         if (beat.last_byte) begin
            window_in = '0;
            seen_in = '0;
            phase_in = PH_SEARCH;
            pos_in = '0;
            hidx_in = '0;
            dest_in = '0;
            src_in = '0;
            type_in = '0;
            cmd_in = '0;
            zeros_in = 1'b1;
            ones_in = 1'b1;
         end else begin
            window_in = win_n;
            seen_in = seen_n;
            phase_in = phase_n;
            pos_in = pos_n;
            hidx_in = hidx_n;
            dest_in = dest_n;
            src_in = src_n;
            type_in = type_n;
            cmd_in = cmd_n;
            zeros_in = zeros_n;
            ones_in = ones_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff <= '0;
         phase_ff <= PH_SEARCH;
         pos_ff <= '0;
         hidx_ff <= '0;
         dest_ff <= '0;
         src_ff <= '0;
         type_ff <= '0;
         cmd_ff <= '0;
         zeros_ff <= 1'b1;
         ones_ff <= 1'b1;
      end else begin
         window_ff <= window_in;
         seen_ff <= seen_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         hidx_ff <= hidx_in;
         dest_ff <= dest_in;
         src_ff <= src_in;
         type_ff <= type_in;
         cmd_ff <= cmd_in;
         zeros_ff <= zeros_in;
         ones_ff <= ones_in;
      end
   end

   // The byte count never passes the capture capacity.
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(CAPTURE_BYTES))
      else $error("byte count beyond capacity");

   // A found sync pattern lies wholly inside the bytes kept so far.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SEARCH |->
         (CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(6) <= (CNT_W + 1)'(seen_ff))
      else $error("sync position past kept bytes");

   // The header counter only moves after a start byte.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEARCH || phase_ff == PH_WANT_START) |-> hidx_ff == 4'd0)
      else $error("header index moved before start byte");

   // An idle cycle leaves the parse state untouched.
   assert property (@(posedge clock) disable iff (reset)
      !beat_valid |=> $stable(seen_ff) && $stable(phase_ff))
      else $error("state changed without a beat");

endmodule

// ----- design/sppp_out_reg.sv -----
module sppp_out_reg
   import sppp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic res_valid,
   input result_type res,
   output logic busy,
   output logic rsp_valid,
   input logic rsp_stall,
   output result_type rsp_res
);

   logic valid_ff;
   logic valid_in;
   result_type res_ff;

   // The register is busy while a result waits on a stalled receiver.
   assign busy = valid_ff && rsp_stall;

   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res = res_ff;

endmodule

// ----- design/sync_pattern_packet_header_parser_core.sv -----
// A beat accepted into the input register updates the parser as it leaves that register; a last
// beat loads its result into the result register, raising rsp_valid, at that same edge.
// Throughput: one byte per cycle, set by the single parse stage between input and result
// registers; a last beat waits only while an earlier result is still stalled on rsp_stall.
// Synchronous reset clears all valids and returns the parser to its sync search state.
module sync_pattern_packet_header_parser_core
   import sppp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_pattern_offset,
   output logic [7:0] rsp_dest_addr,
   output logic [7:0] rsp_source_addr,
   output logic [7:0] rsp_packet_type,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_byte_count
);

   beat_type req_beat;
   beat_type beat;
   logic beat_valid;
   logic hold;
   logic busy;
   logic res_valid;
   result_type res;
   result_type rsp_res;

   assign req_beat.data_byte = req_data_byte;
   assign req_beat.last_byte = req_last_byte;

   // A last beat waits while the result register still holds a stalled result.
   assign hold = beat.last_byte && busy;

   sppp_in_reg u_in_reg (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_beat(req_beat),
      .req_stall(req_stall),
      .hold(hold),
      .beat_valid(beat_valid),
      .beat(beat)
   );

   sppp_parse u_parse (
      .clock(clock),
      .reset(reset),
      .beat_valid(beat_valid),
      .beat(beat),
      .res_valid(res_valid),
      .res(res)
   );

   sppp_out_reg u_out_reg (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res(res),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res(rsp_res)
   );

   assign rsp_status = rsp_res.status;
   assign rsp_pattern_offset = rsp_res.pattern_offset;
   assign rsp_dest_addr = rsp_res.dest_addr;
   assign rsp_source_addr = rsp_res.source_addr;
   assign rsp_packet_type = rsp_res.packet_type;
   assign rsp_command_code = rsp_res.command_code;
   assign rsp_byte_count = rsp_res.byte_count;

endmodule
